@@ src/vcu_pkg.sv @@
package vcu_pkg;

    // Command codes carried by a request
    typedef enum logic [1:0] {
        CMD_LOCAL   = 2'd0,
        CMD_RECEIVE = 2'd1,
        CMD_COMPARE = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SELF   = 2'd1,
        ST_COUNT  = 2'd2,
        ST_CONFIG = 2'd3
    } status_t;

    // Work the back end carries out for one request
    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_BUMP    = 2'd1,
        OP_MERGE   = 2'd2,
        OP_COMPARE = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic CFG_OWN_INDEX  = 1'b0;
    localparam logic CFG_NODE_COUNT = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int ENTRY_W     = 32;
    localparam int PORT_LANES  = 8;

    // Classification passed from front to back
    typedef struct packed {
        op_t     op;
        status_t status;
    } vcu_ctrl_t;

endpackage

@@ src/vcu_req_if.sv @@
interface vcu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [2:0]  peer_index;
    logic [3:0]  peer_count;
    logic [31:0] peer_entry_0;
    logic [31:0] peer_entry_1;
    logic [31:0] peer_entry_2;
    logic [31:0] peer_entry_3;
    logic [31:0] peer_entry_4;
    logic [31:0] peer_entry_5;
    logic [31:0] peer_entry_6;
    logic [31:0] peer_entry_7;

    modport source (
        output valid, command, peer_index, peer_count,
        output peer_entry_0, peer_entry_1, peer_entry_2, peer_entry_3,
        output peer_entry_4, peer_entry_5, peer_entry_6, peer_entry_7,
        input  ready
    );

    modport sink (
        input  valid, command, peer_index, peer_count,
        input  peer_entry_0, peer_entry_1, peer_entry_2, peer_entry_3,
        input  peer_entry_4, peer_entry_5, peer_entry_6, peer_entry_7,
        output ready
    );
endinterface

@@ src/vcu_rsp_if.sv @@
interface vcu_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        before_flag;
    logic [31:0] own_entry_0;
    logic [31:0] own_entry_1;
    logic [31:0] own_entry_2;
    logic [31:0] own_entry_3;
    logic [31:0] own_entry_4;
    logic [31:0] own_entry_5;
    logic [31:0] own_entry_6;
    logic [31:0] own_entry_7;

    modport source (
        output valid, status, before_flag,
        output own_entry_0, own_entry_1, own_entry_2, own_entry_3,
        output own_entry_4, own_entry_5, own_entry_6, own_entry_7,
        input  ready
    );

    modport sink (
        input  valid, status, before_flag,
        input  own_entry_0, own_entry_1, own_entry_2, own_entry_3,
        input  own_entry_4, own_entry_5, own_entry_6, own_entry_7,
        output ready
    );
endinterface

@@ src/vcu_fifo.sv @@
module vcu_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store an incoming request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue occupancy beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg != '0)
        else $error("queue empty after push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree while empty");

endmodule

@@ src/vcu_front.sv @@
module vcu_front #(
    parameter int MAX_NODES    = 8,
    parameter int COUNTER_BITS = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    vcu_req_if.sink                                 req,
    input  logic                                    cfg_we,
    input  logic [vcu_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [vcu_pkg::CFG_DATA_W-1:0]          cfg_data,
    output logic                                    push_valid,
    input  logic                                    push_ready,
    output vcu_pkg::vcu_ctrl_t                      ctrl,
    output logic [MAX_NODES-1:0]                    lane_mask,
    output logic [MAX_NODES-1:0]                    own_sel,
    output logic [MAX_NODES-1:0][COUNTER_BITS-1:0]  peer
);

    localparam logic [31:0] CntMax = 32'((64'd1 << COUNTER_BITS) - 64'd1);

    logic [2:0]  own_index_reg;
    logic [3:0]  node_count_reg;
    logic        cfg_ok;
    logic [31:0] peer_in [vcu_pkg::PORT_LANES];

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_index_reg  <= 3'd0;
            node_count_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vcu_pkg::CFG_OWN_INDEX:  own_index_reg  <= cfg_data[2:0];
                vcu_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

    assign cfg_ok = (node_count_reg != 4'd0) && (node_count_reg <= 4'(MAX_NODES)) &&
                    ({1'b0, own_index_reg} < node_count_reg);

    // Classify the request
    always_comb
    begin
        ctrl.op     = vcu_pkg::OP_NONE;
        ctrl.status = vcu_pkg::ST_OK;
        unique case (req.command)
            vcu_pkg::CMD_LOCAL:
            begin
                if (!cfg_ok)
                    ctrl.status = vcu_pkg::ST_CONFIG;
                else
                    ctrl.op = vcu_pkg::OP_BUMP;
            end
            vcu_pkg::CMD_RECEIVE:
            begin
                if (!cfg_ok)
                    ctrl.status = vcu_pkg::ST_CONFIG;
                else if (req.peer_index == own_index_reg)
                    ctrl.status = vcu_pkg::ST_SELF;
                else if (req.peer_count != node_count_reg)
                    ctrl.status = vcu_pkg::ST_COUNT;
                else
                    ctrl.op = vcu_pkg::OP_MERGE;
            end
            vcu_pkg::CMD_COMPARE:
            begin
                if (!cfg_ok)
                    ctrl.status = vcu_pkg::ST_CONFIG;
                else if (req.peer_count != node_count_reg)
                    ctrl.status = vcu_pkg::ST_COUNT;
                else
                    ctrl.op = vcu_pkg::OP_COMPARE;
            end
            default: ;
        endcase
    end

    assign peer_in[0] = req.peer_entry_0;
    assign peer_in[1] = req.peer_entry_1;
    assign peer_in[2] = req.peer_entry_2;
    assign peer_in[3] = req.peer_entry_3;
    assign peer_in[4] = req.peer_entry_4;
    assign peer_in[5] = req.peer_entry_5;
    assign peer_in[6] = req.peer_entry_6;
    assign peer_in[7] = req.peer_entry_7;

    // Clamp peer entries and mark active and own lanes
    always_comb
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            peer[i]      = (peer_in[i] > CntMax) ? CntMax[COUNTER_BITS-1:0]
                                                 : peer_in[i][COUNTER_BITS-1:0];
            lane_mask[i] = (4'(i) < node_count_reg);
            own_sel[i]   = (own_index_reg == 3'(i));
        end
    end

endmodule

@@ src/vcu_back.sv @@
module vcu_back #(
    parameter int MAX_NODES    = 8,
    parameter int COUNTER_BITS = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    pop_valid,
    output logic                                    pop_ready,
    input  vcu_pkg::vcu_ctrl_t                      ctrl,
    input  logic [MAX_NODES-1:0]                    lane_mask,
    input  logic [MAX_NODES-1:0]                    own_sel,
    input  logic [MAX_NODES-1:0][COUNTER_BITS-1:0]  peer,
    vcu_rsp_if.source                               rsp
);

    localparam logic [COUNTER_BITS-1:0] CntMax = '1;

    logic [MAX_NODES-1:0][COUNTER_BITS-1:0] store_reg, store_next;
    logic [COUNTER_BITS-1:0]                merged [MAX_NODES];
    logic [MAX_NODES-1:0]                   larger, smaller;
    logic                                   rsp_valid_reg;
    logic [1:0]                             status_reg;
    logic                                   before_reg, before_next;
    logic                                   do_pop, bump;
    logic [31:0]                            entry [vcu_pkg::PORT_LANES];

    // Take the next request once the result register is free or drained
    assign pop_ready = !rsp_valid_reg || rsp.ready;
    assign do_pop    = pop_valid && pop_ready;
    assign bump      = (ctrl.op == vcu_pkg::OP_BUMP) || (ctrl.op == vcu_pkg::OP_MERGE);

    // Merge, increment and compare lane by lane
    always_comb
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            merged[i] = (ctrl.op == vcu_pkg::OP_MERGE && lane_mask[i] &&
                         peer[i] > store_reg[i]) ? peer[i] : store_reg[i];
            store_next[i] = (bump && own_sel[i] && merged[i] != CntMax)
                            ? merged[i] + 1'b1 : merged[i];
            larger[i]  = lane_mask[i] && (store_reg[i] > peer[i]);
            smaller[i] = lane_mask[i] && (store_reg[i] < peer[i]);
        end
        before_next = (ctrl.op == vcu_pkg::OP_COMPARE) && !(|larger) && (|smaller);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_pop)
            begin
                store_reg <= store_next;
            end
            if (pop_ready)
            begin
                rsp_valid_reg <= pop_valid;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            status_reg <= ctrl.status;
            before_reg <= before_next;
        end
    end

    // The clock only changes on a pop, so the store is the reported clock
    generate
        for (genvar k = 0; k < vcu_pkg::PORT_LANES; k++)
        begin : g_entry
            if (k < MAX_NODES)
            begin : g_used
                assign entry[k] = 32'(store_reg[k]);
            end
            else
            begin : g_unused
                assign entry[k] = '0;
            end
        end
    endgenerate

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.before_flag = before_reg;
    assign rsp.own_entry_0 = entry[0];
    assign rsp.own_entry_1 = entry[1];
    assign rsp.own_entry_2 = entry[2];
    assign rsp.own_entry_3 = entry[3];
    assign rsp.own_entry_4 = entry[4];
    assign rsp.own_entry_5 = entry[5];
    assign rsp.own_entry_6 = entry[6];
    assign rsp.own_entry_7 = entry[7];

    assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && (ctrl.status != vcu_pkg::ST_OK) |=> $stable(store_reg))
        else $error("clock changed on a failed request");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> $stable(store_reg))
        else $error("clock changed while a result is stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.before_flag |-> rsp.status == vcu_pkg::ST_OK)
        else $error("before flag set on a failed request");

endmodule

@@ src/vector_clock_unit.sv @@
// Path: an accepted request is written into the queue, then popped into the result register that drives rsp.
// Throughput: one request per cycle while rsp is not stalled; a two-entry queue between the
// classify stage and the clock update takes requests during output stalls until it is full.
// The update path is one compare-select and one increment per entry.
// Reset: all clock entries zero, own_index 0, node_count 8, queue empty.
module vector_clock_unit #(
    parameter int MAX_NODES    = 8,
    parameter int COUNTER_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    vcu_req_if.sink                          req,
    vcu_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [vcu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vcu_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CTRL_W  = $bits(vcu_pkg::vcu_ctrl_t);
    localparam int PEER_W  = MAX_NODES * COUNTER_BITS;
    localparam int ITEM_W  = CTRL_W + 2 * MAX_NODES + PEER_W;

    logic                                    push_valid, push_ready;
    logic                                    pop_valid, pop_ready;
    vcu_pkg::vcu_ctrl_t                      f_ctrl, b_ctrl;
    logic [MAX_NODES-1:0]                    f_mask, b_mask;
    logic [MAX_NODES-1:0]                    f_own, b_own;
    logic [MAX_NODES-1:0][COUNTER_BITS-1:0]  f_peer, b_peer;
    logic [ITEM_W-1:0]                       push_data, pop_data;

    vcu_front #(
        .MAX_NODES    (MAX_NODES),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .ctrl       (f_ctrl),
        .lane_mask  (f_mask),
        .own_sel    (f_own),
        .peer       (f_peer)
    );

    assign push_data = {f_ctrl, f_mask, f_own, f_peer};

    vcu_fifo #(
        .WIDTH (ITEM_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign {b_ctrl, b_mask, b_own, b_peer} = pop_data;

    vcu_back #(
        .MAX_NODES    (MAX_NODES),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .ctrl      (b_ctrl),
        .lane_mask (b_mask),
        .own_sel   (b_own),
        .peer      (b_peer),
        .rsp       (rsp)
    );

endmodule

@@ dv/vclock_checker.sv @@
module vclock_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    vcu_req_if                              req,
    vcu_rsp_if                              rsp,
    input  logic                            cfg_we,
    input  logic [vcu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [vcu_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              outstanding
);

    localparam int NODES = vcu_pkg::PORT_LANES;
    localparam logic [vcu_pkg::ENTRY_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        vcu_pkg::status_t                        status;
        logic                                    before_flag;
        logic [NODES-1:0][vcu_pkg::ENTRY_W-1:0]  entries;
    } clock_result_t;

    // Mirror of the node's clock and its two registers
    logic [2:0]                  own_idx;
    logic [3:0]                  n_used;
    logic [vcu_pkg::ENTRY_W-1:0] vc [NODES];

    clock_result_t expected_q [$];

    // Saturating increment of this node's own entry
    task automatic tick_own();
        if (vc[own_idx] != COUNT_MAX)
            vc[own_idx] = vc[own_idx] + 1'b1;
    endtask

    // Apply one request to the mirrored clock and form its result
    task automatic advance_clock(
        input  logic [1:0]                             cmd,
        input  logic [2:0]                             pidx,
        input  logic [3:0]                             pcnt,
        input  logic [NODES-1:0][vcu_pkg::ENTRY_W-1:0] peer,
        output clock_result_t                          res
    );
        logic cfg_ok;
        logic larger;
        logic smaller;
        cfg_ok  = n_used >= 1 && n_used <= NODES && own_idx < n_used;
        larger  = 1'b0;
        smaller = 1'b0;
        res.status      = vcu_pkg::ST_OK;
        res.before_flag = 1'b0;
        case (cmd)
            vcu_pkg::CMD_LOCAL, vcu_pkg::CMD_RECEIVE, vcu_pkg::CMD_COMPARE:
            begin
                if (!cfg_ok)
                    res.status = vcu_pkg::ST_CONFIG;
                else if (cmd == vcu_pkg::CMD_LOCAL)
                    tick_own();
                else if (cmd == vcu_pkg::CMD_RECEIVE)
                begin
                    if (pidx == own_idx)
                        res.status = vcu_pkg::ST_SELF;
                    else if (pcnt != n_used)
                        res.status = vcu_pkg::ST_COUNT;
                    else
                    begin
                        // Merge by maximum over the entries in use
                        for (int i = 0; i < n_used; i++)
                            if (peer[i] > vc[i])
                                vc[i] = peer[i];
                        tick_own();
                    end
                end
                else if (pcnt != n_used)
                    res.status = vcu_pkg::ST_COUNT;
                else
                begin
                    // Strictly before: nothing ahead of the peer, something behind
                    for (int i = 0; i < n_used; i++)
                    begin
                        if (vc[i] > peer[i])
                            larger = 1'b1;
                        else if (vc[i] < peer[i])
                            smaller = 1'b1;
                    end
                    res.before_flag = !larger && smaller;
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < NODES; i++)
            res.entries[i] = vc[i];
    endtask

    // Compare one result against the oldest expectation
    task automatic check_result(input clock_result_t want, input clock_result_t got);
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.before_flag !== want.before_flag)
        begin
            $error("before_flag: expected %0d, got %0d", want.before_flag, got.before_flag);
            mismatches++;
        end
        for (int i = 0; i < NODES; i++)
            if (got.entries[i] !== want.entries[i])
            begin
                $error("own_entry_%0d: expected %h, got %h",
                       i, want.entries[i], got.entries[i]);
                mismatches++;
            end
    endtask

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        clock_result_t got;
        clock_result_t want;
        if (!rst_n)
        begin
            own_idx = '0;
            n_used  = 4'd8;
            for (int i = 0; i < NODES; i++)
                vc[i] = '0;
            expected_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // Retire a result before taking a new request
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.status, rsp.before_flag,
                       rsp.own_entry_7, rsp.own_entry_6, rsp.own_entry_5, rsp.own_entry_4,
                       rsp.own_entry_3, rsp.own_entry_2, rsp.own_entry_1, rsp.own_entry_0};
                if (expected_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_result(want, got);
                end
            end
            if (req.valid && req.ready)
            begin
                advance_clock(req.command, req.peer_index, req.peer_count,
                              {req.peer_entry_7, req.peer_entry_6, req.peer_entry_5,
                               req.peer_entry_4, req.peer_entry_3, req.peer_entry_2,
                               req.peer_entry_1, req.peer_entry_0},
                              want);
                expected_q.push_back(want);
            end
            if (cfg_we)
            begin
                if (cfg_index == vcu_pkg::CFG_OWN_INDEX)
                    own_idx = cfg_data[2:0];
                else if (cfg_index == vcu_pkg::CFG_NODE_COUNT)
                    n_used = cfg_data;
            end
            outstanding = expected_q.size();
        end
    end

endmodule

@@ dv/tb_vector_clock_unit.sv @@
module tb_vector_clock_unit;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1130;
    localparam int         QUIET_TAIL   = 150;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam logic [31:0] TOP = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    logic                             cfg_we;
    logic [vcu_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [vcu_pkg::CFG_DATA_W-1:0]   cfg_data;

    int mismatches;
    int outstanding;
    int cycle_count;
    int sent;
    int stall_left;
    bit idle_on;

    // Tracked register values and the most recent clock seen on the output
    logic [2:0]        own_cfg;
    logic [3:0]        count_cfg;
    logic [7:0][31:0]  last_seen;

    vcu_req_if req ();
    vcu_rsp_if rsp ();

    vector_clock_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    vclock_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("vector_clock_unit verification failed");
            $finish;
        end
    end

    // Hold off results in short random bursts
    always
    begin
        @(negedge clk);
        if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 5);
        if (stall_left > 0)
        begin
            rsp.ready <= 1'b0;
            stall_left--;
        end
        else
            rsp.ready <= 1'b1;
    end

    // Keep the last clock that came out, to build peer clocks near it
    always @(posedge clk)
        if (rsp.valid && rsp.ready)
            last_seen <= {rsp.own_entry_7, rsp.own_entry_6, rsp.own_entry_5,
                          rsp.own_entry_4, rsp.own_entry_3, rsp.own_entry_2,
                          rsp.own_entry_1, rsp.own_entry_0};

    // Offer one request, with an optional gap first, and wait for acceptance
    task automatic send_request(
        input logic [1:0]       cmd,
        input logic [2:0]       pidx,
        input logic [3:0]       pcnt,
        input logic [7:0][31:0] ent
    );
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        req.valid        <= 1'b1;
        req.command      <= cmd;
        req.peer_index   <= pidx;
        req.peer_count   <= pcnt;
        req.peer_entry_0 <= ent[0];
        req.peer_entry_1 <= ent[1];
        req.peer_entry_2 <= ent[2];
        req.peer_entry_3 <= ent[3];
        req.peer_entry_4 <= ent[4];
        req.peer_entry_5 <= ent[5];
        req.peer_entry_6 <= ent[6];
        req.peer_entry_7 <= ent[7];
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Drop valid and wait for every result to come back
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_config(
        input logic [vcu_pkg::CFG_INDEX_W-1:0] idx,
        input logic [vcu_pkg::CFG_DATA_W-1:0]  data
    );
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // Reprogram both registers while the block is idle
    task automatic set_config(input logic [3:0] own_data, input logic [3:0] count_data);
        wait_drained();
        write_config(vcu_pkg::CFG_OWN_INDEX, own_data);
        write_config(vcu_pkg::CFG_NODE_COUNT, count_data);
        cfg_we    <= 1'b0;
        own_cfg   = own_data[2:0];
        count_cfg = count_data;
    endtask

    // Move a value by a small random step, clamped to the counter range
    function automatic logic [31:0] nudge(input logic [31:0] base, input int lo, input int hi);
        longint v;
        v = longint'(base) + longint'($urandom_range(0, hi - lo)) + lo;
        if (v < 0)
            v = 0;
        if (v > longint'(TOP))
            v = longint'(TOP);
        return v[31:0];
    endfunction

    // Build and send one random request, mostly well-formed
    task automatic send_random();
        logic [1:0]       cmd;
        logic [2:0]       pidx;
        logic [3:0]       pcnt;
        logic [7:0][31:0] ent;
        int               sel;
        int               mode;
        sel = $urandom_range(0, 19);
        if (sel < 5)
            cmd = vcu_pkg::CMD_LOCAL;
        else if (sel < 12)
            cmd = vcu_pkg::CMD_RECEIVE;
        else if (sel < 19)
            cmd = vcu_pkg::CMD_COMPARE;
        else
            cmd = CMD_UNUSED;

        if (cmd == vcu_pkg::CMD_RECEIVE && $urandom_range(0, 9) != 0)
            pidx = own_cfg + 3'($urandom_range(1, 7));
        else
            pidx = 3'($urandom_range(0, 7));
        pcnt = ($urandom_range(0, 9) != 0) ? count_cfg : 4'($urandom_range(0, 15));

        mode = (cmd == vcu_pkg::CMD_LOCAL || cmd == CMD_UNUSED) ? 0 : $urandom_range(0, 9);
        for (int i = 0; i < 8; i++)
        begin
            if (mode <= 1)
                ent[i] = $urandom();
            else if (mode == 2)
                ent[i] = $urandom_range(0, 15);
            else if (mode <= 5)
                ent[i] = nudge(last_seen[i], -3, 3);
            else if (mode <= 8)
                ent[i] = nudge(last_seen[i], 0, 2);
            else
                ent[i] = last_seen[i];
        end
        send_request(cmd, pidx, pcnt, ent);
    endtask

    initial
    begin
        int          phase;
        int          phase_len;
        int          pick;
        logic [3:0]  own_data;
        logic [3:0]  count_data;
        logic [2:0]  own_val;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        req.valid        = 1'b0;
        req.command      = vcu_pkg::CMD_LOCAL;
        req.peer_index   = '0;
        req.peer_count   = '0;
        req.peer_entry_0 = '0;
        req.peer_entry_1 = '0;
        req.peer_entry_2 = '0;
        req.peer_entry_3 = '0;
        req.peer_entry_4 = '0;
        req.peer_entry_5 = '0;
        req.peer_entry_6 = '0;
        req.peer_entry_7 = '0;
        rsp.ready  = 1'b0;
        own_cfg    = 3'd0;
        count_cfg  = 4'd8;
        last_seen  = '0;
        idle_on    = 1'b1;
        stall_left = 0;
        sent       = 0;
        cycle_count = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset settings, own index 0 over eight entries
        send_request(vcu_pkg::CMD_LOCAL, 3'd0, 4'd8, '0);
        // receive from self
        send_request(vcu_pkg::CMD_RECEIVE, 3'd0, 4'd8, {8{TOP}});
        // receive with a count mismatch
        send_request(vcu_pkg::CMD_RECEIVE, 3'd1, 4'd5, {8{TOP}});
        // merge, pushing the last entry to the counter maximum
        send_request(vcu_pkg::CMD_RECEIVE, 3'd1, 4'd8,
                     {TOP, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd2, 32'd3});
        // compare: equal, strictly behind, concurrent
        send_request(vcu_pkg::CMD_COMPARE, 3'd2, 4'd8,
                     {TOP, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd2, 32'd4});
        send_request(vcu_pkg::CMD_COMPARE, 3'd2, 4'd8,
                     {TOP, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd3, 32'd4});
        send_request(vcu_pkg::CMD_COMPARE, 3'd2, 4'd8,
                     {TOP, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd5});
        // compare with a count mismatch
        send_request(vcu_pkg::CMD_COMPARE, 3'd7, 4'd15, '0);
        // unused command
        send_request(CMD_UNUSED, 3'd7, 4'd15, {8{TOP}});
        // merge of an all-zero peer only bumps the own entry
        send_request(vcu_pkg::CMD_RECEIVE, 3'd7, 4'd8, '0);

        // Own entry already at the maximum must hold there
        set_config(4'd7, 4'd8);
        send_request(vcu_pkg::CMD_LOCAL, 3'd0, 4'd8, '0);
        send_request(vcu_pkg::CMD_RECEIVE, 3'd7, 4'd8, '0);

        // Bad settings: no entries, too many entries, own index out of range
        set_config(4'd0, 4'd0);
        send_request(vcu_pkg::CMD_LOCAL, 3'd1, 4'd0, '0);
        send_request(vcu_pkg::CMD_RECEIVE, 3'd1, 4'd0, {8{TOP}});
        send_request(vcu_pkg::CMD_COMPARE, 3'd1, 4'd0, {8{TOP}});
        send_request(CMD_UNUSED, 3'd1, 4'd0, '0);
        set_config(4'd0, 4'd9);
        send_request(vcu_pkg::CMD_LOCAL, 3'd1, 4'd9, '0);
        set_config(4'd8, 4'd15);
        send_request(vcu_pkg::CMD_COMPARE, 3'd1, 4'd15, {8{TOP}});
        set_config(4'd4, 4'd4);
        send_request(vcu_pkg::CMD_RECEIVE, 3'd1, 4'd4, '0);

        // Single entry: increment up to the maximum, then saturate;
        // entries past the count stay out of merge and compare
        set_config(4'd0, 4'd1);
        send_request(vcu_pkg::CMD_RECEIVE, 3'd5, 4'd1, {{7{TOP}}, 32'hFFFF_FFFE});
        send_request(vcu_pkg::CMD_LOCAL, 3'd5, 4'd1, '0);
        send_request(vcu_pkg::CMD_COMPARE, 3'd5, 4'd1, {{7{32'd0}}, TOP});

        // Random phases, each under its own register setting
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase == 0)
            begin
                own_data   = 4'd7;
                count_data = 4'd8;
            end
            else if (phase == 1)
            begin
                own_data   = 4'd0;
                count_data = 4'd1;
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 8)
                begin
                    count_data = 4'($urandom_range(1, 8));
                    own_val    = 3'($urandom_range(0, count_data - 1));
                end
                else if (pick == 8)
                begin
                    count_data = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
                    own_val    = 3'($urandom_range(0, 7));
                end
                else
                begin
                    count_data = 4'($urandom_range(1, 7));
                    own_val    = 3'($urandom_range(count_data, 7));
                end
                own_data = {1'($urandom_range(0, 1)), own_val};
            end
            set_config(own_data, count_data);

            // Bad settings only report errors, so keep those phases short
            if (count_data == 0 || count_data > 8 || own_data[2:0] >= count_data)
                phase_len = 16;
            else
                phase_len = 110;

            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++)
            begin
                if (n % 30 == 0)
                    idle_on = (sent < RANDOM_ITEMS - QUIET_TAIL) && $urandom_range(0, 2) != 0;
                send_random();
            end
            phase++;
        end

        // Let the last results come out, then give the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("vector_clock_unit verification clean");
        else
            $display("vector_clock_unit verification failed");
        $finish;
    end

endmodule
